@@ sv/pit_pkg.sv @@
// ----------------------------------------------------------------------------
// pit_pkg: shared types and codes for the three-channel interval timer
// Item layout, item kinds, register offsets, access and counting mode codes.
// ----------------------------------------------------------------------------
package pit_pkg;

  localparam int CHANNELS = 3;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_GATE  = 2'd3
  } kind_t;

  // fields from the lowest bit up: kind, port, data
  typedef struct packed {
    logic [7:0] data;
    logic [1:0] port;
    kind_t      kind;
  } item_t;

  // fields from the lowest bit up: read_data, out0, out1, out2
  typedef struct packed {
    logic       out2;
    logic       out1;
    logic       out0;
    logic [7:0] read_data;
  } res_t;

  localparam int ITEM_W = $bits(item_t);
  localparam int RES_W  = $bits(res_t);

  localparam logic [1:0] CTRL_PORT    = 2'd3;
  localparam logic [1:0] SEL_READBACK = 2'd3;

  // access modes, also latch states
  localparam logic [1:0] ACC_LATCH = 2'd0;
  localparam logic [1:0] ACC_LSB   = 2'd1;
  localparam logic [1:0] ACC_MSB   = 2'd2;
  localparam logic [1:0] ACC_WORD  = 2'd3;

  // read / write byte phases
  localparam logic [2:0] PH_MSB     = 3'd2;
  localparam logic [2:0] PH_WORD_LO = 3'd3;
  localparam logic [2:0] PH_WORD_HI = 3'd4;

  // counting modes
  localparam logic [2:0] MODE_INT_TC    = 3'd0;
  localparam logic [2:0] MODE_ONE_SHOT  = 3'd1;
  localparam logic [2:0] MODE_RATE      = 3'd2;
  localparam logic [2:0] MODE_SQUARE    = 3'd3;
  localparam logic [2:0] MODE_SW_STROBE = 3'd4;
  localparam logic [2:0] MODE_HW_STROBE = 3'd5;

  localparam logic [16:0] COUNT_FULL = 17'h10000;

endpackage

@@ sv/pit_chan.sv @@
// ----------------------------------------------------------------------------
// pit_chan: one timer channel
// Holds count, elapsed ticks, modes and read/latch sequencing of one channel;
// applies one item per go cycle and reports its read byte and new output level.
// ----------------------------------------------------------------------------
module pit_chan #(
  parameter int   CH        = 0,
  parameter logic GATE_INIT = 1'b1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            go,
  input  pit_pkg::item_t  item,
  output logic [7:0]      rd,
  output logic            lvl
);

  logic [16:0] icount, icount_next;
  logic [15:0] elapsed, elapsed_next;
  logic [16:0] phase, phase_next;
  logic        ge, ge_next, gt, gt_next;
  logic        started, started_next;
  logic [2:0]  mode, mode_next;
  logic        bcd, bcd_next;
  logic [1:0]  acc, acc_next;
  logic [2:0]  rphase, rphase_next;
  logic [2:0]  wphase, wphase_next;
  logic [7:0]  low_hold, low_hold_next;
  logic [15:0] latched, latched_next;
  logic [1:0]  lstate, lstate_next;
  logic [7:0]  status, status_next;
  logic        held, held_next;
  logic        gate, gate_next;

  logic [16:0] cv;
  logic        lvl_cur;
  logic        hit, ctrl;
  logic        do_latch, do_status, do_load;
  logic [15:0] load_val;

  function automatic logic [16:0] count_value(input logic [2:0] m, input logic [16:0] n,
                                              input logic [15:0] el, input logic [16:0] ph);
    logic [17:0] t;
    logic [16:0] v;
    t = {ph, 1'b0};
    v = n - ph;
    case (m)
      pit_pkg::MODE_INT_TC, pit_pkg::MODE_ONE_SHOT,
      pit_pkg::MODE_SW_STROBE, pit_pkg::MODE_HW_STROBE: begin
        v = {1'b0, n[15:0] - el};
      end
      pit_pkg::MODE_SQUARE: begin
        if (t >= {1'b0, n}) t = t - {1'b0, n};
        v = n - t[16:0];
      end
      default: v = n - ph;
    endcase
    return v;
  endfunction

  function automatic logic out_level(input logic [2:0] m, input logic [16:0] n,
                                     input logic [16:0] ph, input logic g_e,
                                     input logic g_t, input logic st);
    logic [17:0] half;
    logic        o;
    half = ({1'b0, n} + 18'd1) >> 1;
    case (m)
      pit_pkg::MODE_RATE:   o = (ph == '0) && st;
      pit_pkg::MODE_SQUARE: o = {1'b0, ph} < half;
      pit_pkg::MODE_SW_STROBE, pit_pkg::MODE_HW_STROBE: o = g_e && !g_t;
      default: o = g_e;
    endcase
    return o;
  endfunction

  assign cv      = count_value(mode, icount, elapsed, phase);
  assign lvl_cur = out_level(mode, icount, phase, ge, gt, started);
  assign hit     = item.port == 2'(CH);
  assign ctrl    = item.port == pit_pkg::CTRL_PORT;

  always_comb begin
    icount_next   = icount;
    elapsed_next  = elapsed;
    phase_next    = phase;
    ge_next       = ge;
    gt_next       = gt;
    started_next  = started;
    mode_next     = mode;
    bcd_next      = bcd;
    acc_next      = acc;
    rphase_next   = rphase;
    wphase_next   = wphase;
    low_hold_next = low_hold;
    latched_next  = latched;
    lstate_next   = lstate;
    status_next   = status;
    held_next     = held;
    gate_next     = gate;
    rd            = '0;
    do_latch      = 1'b0;
    do_status     = 1'b0;
    do_load       = 1'b0;
    load_val      = {8'h00, item.data};

    if (go) begin
      case (item.kind)
        pit_pkg::KIND_WRITE: begin
          if (ctrl) begin
            if (item.data[7:6] == pit_pkg::SEL_READBACK) begin
              if (item.data[CH+1]) begin
                do_latch  = !item.data[5];
                do_status = !item.data[4] && !held;
              end
            end else if (item.data[7:6] == 2'(CH)) begin
              if (item.data[5:4] == pit_pkg::ACC_LATCH) begin
                do_latch = 1'b1;
              end else begin
                acc_next    = item.data[5:4];
                rphase_next = {1'b0, item.data[5:4]};
                wphase_next = {1'b0, item.data[5:4]};
                mode_next   = item.data[3:1];
                bcd_next    = item.data[0];
              end
            end
          end else if (hit) begin
            case (wphase)
              pit_pkg::PH_MSB: begin
                do_load  = 1'b1;
                load_val = {item.data, 8'h00};
              end
              pit_pkg::PH_WORD_LO: begin
                low_hold_next = item.data;
                wphase_next   = pit_pkg::PH_WORD_HI;
              end
              pit_pkg::PH_WORD_HI: begin
                do_load     = 1'b1;
                load_val    = {item.data, low_hold};
                wphase_next = pit_pkg::PH_WORD_LO;
              end
              default: do_load = 1'b1;
            endcase
          end
        end
        pit_pkg::KIND_READ: begin
          if (hit) begin
            if (held) begin
              held_next = 1'b0;
              rd        = status;
            end else if (lstate != pit_pkg::ACC_LATCH) begin
              case (lstate)
                pit_pkg::ACC_MSB: begin
                  rd          = latched[15:8];
                  lstate_next = pit_pkg::ACC_LATCH;
                end
                pit_pkg::ACC_WORD: begin
                  rd          = latched[7:0];
                  lstate_next = pit_pkg::ACC_MSB;
                end
                default: begin
                  rd          = latched[7:0];
                  lstate_next = pit_pkg::ACC_LATCH;
                end
              endcase
            end else begin
              case (rphase)
                pit_pkg::PH_MSB: rd = cv[15:8];
                pit_pkg::PH_WORD_LO: begin
                  rd          = cv[7:0];
                  rphase_next = pit_pkg::PH_WORD_HI;
                end
                pit_pkg::PH_WORD_HI: begin
                  rd          = cv[15:8];
                  rphase_next = pit_pkg::PH_WORD_LO;
                end
                default: rd = cv[7:0];
              endcase
            end
          end
        end
        pit_pkg::KIND_TICK: begin
          if (!ge) begin
            if ({1'b0, elapsed} + 17'd1 >= icount) ge_next = 1'b1;
          end else begin
            gt_next = 1'b1;
          end
          elapsed_next = elapsed + 16'd1;
          phase_next   = (phase + 17'd1 >= icount) ? '0 : phase + 17'd1;
          started_next = 1'b1;
        end
        pit_pkg::KIND_GATE: begin
          if (hit) begin
            if ((mode == pit_pkg::MODE_ONE_SHOT || mode == pit_pkg::MODE_RATE ||
                 mode == pit_pkg::MODE_SQUARE || mode == pit_pkg::MODE_HW_STROBE) &&
                !gate && item.data[0]) begin
              elapsed_next = '0;
              phase_next   = '0;
              ge_next      = 1'b0;
              gt_next      = 1'b0;
              started_next = 1'b0;
            end
            gate_next = item.data[0];
          end
        end
        default: ;
      endcase

      if (do_latch && lstate == pit_pkg::ACC_LATCH) begin
        latched_next = cv[15:0];
        lstate_next  = acc;
      end
      if (do_status) begin
        status_next = {lvl_cur, 1'b0, acc, mode, bcd};
        held_next   = 1'b1;
      end
      if (do_load) begin
        icount_next  = (load_val == '0) ? pit_pkg::COUNT_FULL : {1'b0, load_val};
        elapsed_next = '0;
        phase_next   = '0;
        ge_next      = 1'b0;
        gt_next      = 1'b0;
        started_next = 1'b0;
      end
    end

    lvl = out_level(mode_next, icount_next, phase_next, ge_next, gt_next, started_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      icount   <= pit_pkg::COUNT_FULL;
      elapsed  <= '0;
      phase    <= '0;
      ge       <= 1'b0;
      gt       <= 1'b0;
      started  <= 1'b0;
      mode     <= pit_pkg::MODE_SQUARE;
      bcd      <= 1'b0;
      acc      <= pit_pkg::ACC_LATCH;
      rphase   <= '0;
      wphase   <= '0;
      low_hold <= '0;
      latched  <= '0;
      lstate   <= pit_pkg::ACC_LATCH;
      status   <= '0;
      held     <= 1'b0;
      gate     <= GATE_INIT;
    end else begin
      icount   <= icount_next;
      elapsed  <= elapsed_next;
      phase    <= phase_next;
      ge       <= ge_next;
      gt       <= gt_next;
      started  <= started_next;
      mode     <= mode_next;
      bcd      <= bcd_next;
      acc      <= acc_next;
      rphase   <= rphase_next;
      wphase   <= wphase_next;
      low_hold <= low_hold_next;
      latched  <= latched_next;
      lstate   <= lstate_next;
      status   <= status_next;
      held     <= held_next;
      gate     <= gate_next;
    end
  end

endmodule

@@ sv/pit_ofifo.sv @@
// ----------------------------------------------------------------------------
// pit_ofifo: two-entry result queue
// Decouples result production from the downstream ready.
// ----------------------------------------------------------------------------
module pit_ofifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pit_pkg::res_t wdata,
  input  logic          pop,
  output pit_pkg::res_t rdata,
  output logic          valid,
  output logic          full
);

  pit_pkg::res_t mem [2];
  logic       wptr, rptr;
  logic [1:0] count;

  assign valid = count != 2'd0;
  assign full  = count == 2'd2;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop && valid) rptr <= ~rptr;
      case ({push, pop && valid})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ sv/programmable_interval_timer_3ch.sv @@
// ----------------------------------------------------------------------------
// programmable_interval_timer_3ch: three-channel 8254-style interval timer
// Byte-wide register port, counter-clock ticks and gate changes as items;
// one result item per input item.
//
//   channel  dir  width  fields (low bit first)
//   s_*      in   16     kind[1:0] port[3:2] data[11:4]
//   m_*      out  16     read_data[7:0] out0[8] out1[9] out2[10]
//
// One item per cycle sustained while the queue has room; an item is held in
// the input register and applied to all channels when the queue has room; its
// result then waits in a two-entry queue and is valid once written there.
// Synchronous reset puts every channel in mode 3 with a count of 65536.
// With the queue full an item in the input register holds and s_tready drops.
// ----------------------------------------------------------------------------
module programmable_interval_timer_3ch #(
  parameter int CHANNELS = pit_pkg::CHANNELS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // kind, port, data
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // read_data, out0, out1, out2
);

  pit_pkg::item_t in_item;
  logic           in_valid;
  logic           proc;
  logic           q_full;
  pit_pkg::res_t  res, q_data;
  logic [7:0]     rd   [CHANNELS];
  logic           lvl  [CHANNELS];
  logic [7:0]     rd_any;

  assign s_tready = !in_valid || !q_full;
  assign proc     = in_valid && !q_full;

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) in_item <= pit_pkg::item_t'(s_tdata[pit_pkg::ITEM_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (proc) begin
      in_valid <= 1'b0;
    end
  end

  for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
    localparam logic GI = (c != 2);
    pit_chan #(.CH(c), .GATE_INIT(GI)) u_chan (
      .clk  (clk),
      .rst  (rst),
      .go   (proc),
      .item (in_item),
      .rd   (rd[c]),
      .lvl  (lvl[c])
    );
  end

  always_comb begin
    rd_any = '0;
    for (int c = 0; c < CHANNELS; c++) rd_any = rd_any | rd[c];
  end

  assign res.read_data = rd_any;
  assign res.out0      = lvl[0];
  assign res.out1      = lvl[1];
  assign res.out2      = lvl[2];

  pit_ofifo u_ofifo (
    .clk   (clk),
    .rst   (rst),
    .push  (proc),
    .wdata (res),
    .pop   (m_tready),
    .rdata (q_data),
    .valid (m_tvalid),
    .full  (q_full)
  );

  assign m_tdata = {(16 - pit_pkg::RES_W)'(0), q_data};

  a_ctrl_read_zero: assert property (@(posedge clk) disable iff (rst)
    proc && in_item.kind == pit_pkg::KIND_READ && in_item.port == pit_pkg::CTRL_PORT
    |-> res.read_data == 8'h00)
    else $error("read of control port returned nonzero data");

  a_nonread_zero: assert property (@(posedge clk) disable iff (rst)
    proc && in_item.kind != pit_pkg::KIND_READ |-> res.read_data == 8'h00)
    else $error("nonzero read data for a non-read item");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    in_valid && !proc |=> in_valid && $stable(in_item))
    else $error("stalled item lost from input register");

  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    proc |=> m_tvalid)
    else $error("processed item produced no visible result");

endmodule
